/* hdl/shortlex_word_unrank_macros.svh */
// assertion macros for the shortlex word unranking block
// used by shortlex_word_unrank.sv, no other dependencies
`ifndef SHORTLEX_WORD_UNRANK_MACROS_SVH
`define SHORTLEX_WORD_UNRANK_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SLWU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slwu assertion failed");
// next-cycle implication, disabled during reset
`define SLWU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slwu assertion failed");
`else
`define SLWU_ASSERT_IMP(label, clk, rst, ante, cons)
`define SLWU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/slwu_pkg.sv */
// shared types, constants and helpers for the shortlex word unranking block
// no dependencies
package slwu_pkg;

  localparam int MAX_LEN    = 32;
  localparam int INDEX_BITS = 48;

  // port widths
  localparam int INDEX_W = 48;
  localparam int RADIX_W = 5;
  localparam int LEN_W   = 6;
  localparam int POS_W   = 5;
  localparam int DIGIT_W = 4;

  localparam int RADIX_MAX = 16;

  // index bits that take part in the decode
  localparam int USE_BITS = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  // room for the remainder, r^m and a shifted power
  localparam int WIDE_W   = USE_BITS + DIGIT_W + 1;
  localparam int SHIFT_W  = $clog2(DIGIT_W);
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } state_t;

  // operand select for the shared compare-subtract unit
  typedef struct packed {
    logic               use_q;
    logic [SHIFT_W-1:0] shift;
  } csub_op_t;

  // radix saturated into 1..16
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = RADIX_W'(1);
    end else if (r > RADIX_W'(RADIX_MAX)) begin
      res = RADIX_W'(RADIX_MAX);
    end
    return res;
  endfunction

endpackage

/* hdl/slwu_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module slwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/slwu_csub.sv */
// shared compare-subtract unit: remainder against r^m or a shifted power
// depends on slwu_pkg
module slwu_csub import slwu_pkg::*; (
  input  csub_op_t          op,
  input  logic [WIDE_W-1:0] rem,
  input  logic [WIDE_W-1:0] p,
  input  logic [WIDE_W-1:0] q,
  output logic              ge,
  output logic [WIDE_W-1:0] diff
);

  logic [WIDE_W-1:0] b;

  always_comb begin
    b    = op.use_q ? (q << op.shift) : p;
    ge   = (rem >= b);
    diff = rem - b;
  end

endmodule

/* hdl/shortlex_word_unrank.sv */
// Shortlex word unranking. A transfer on the item channel gives an index; the block
// returns the word at that shortlex position over an alphabet of cfg_radix letters,
// one result transfer per letter, most significant first, last set on the final one.
// Index 0 is the one-letter word 0. A radix of 0 acts as 1, above 16 as 16; with one
// letter the word is index+1 zeros. A word longer than MAX_LEN gives one result with
// too_long set. Work is one item at a time on a single compare-subtract unit: the
// length search tries one length after another, storing r^k in a small ram as it
// goes, then each letter takes one ram read, four compare-subtract steps and one
// output transfer; a one-letter alphabet skips the search, the ram read and the steps.
// depends on slwu_pkg, slwu_ram, slwu_csub and shortlex_word_unrank_macros.svh
`include "shortlex_word_unrank_macros.svh"

module shortlex_word_unrank import slwu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_radix,
  // input items
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [INDEX_W-1:0] index,
  // results
  output logic               result_valid,
  input  logic               result_ready,
  output logic [LEN_W-1:0]   word_length,
  output logic [POS_W-1:0]   position,
  output logic [DIGIT_W-1:0] digit,
  output logic               last,
  output logic               too_long
);

  state_t state, state_next;

  logic [RADIX_W-1:0] radix;       // register as written
  logic [RADIX_W-1:0] r_cl;        // saturated radix
  logic [RADIX_W-1:0] radix_used;  // radix captured for the current item

  logic [WIDE_W-1:0]  rem;         // offset, then the part still to be split into digits
  logic [WIDE_W-1:0]  p;           // r^m during the length search
  logic [LEN_W-1:0]   m;           // word length
  logic [LEN_W-1:0]   pos;         // letter being produced
  logic [SHIFT_W-1:0] bit_cnt;     // digit bit under trial
  logic [DIGIT_W-1:0] dig;         // digit bits found so far
  logic               unary;

  logic                        item_xfer, result_xfer;
  logic [WIDE_W-1:0]           x_ext;
  logic                        x_too_big;
  logic [WIDE_W+RADIX_W-1:0]   prod;
  logic [LEN_W-1:0]            ridx;
  logic [DIGIT_W-1:0]          dig_next;
  logic                        at_max;
  logic                        is_last_pos;

  // shared unit and power table
  csub_op_t          op;
  logic              ge;
  logic [WIDE_W-1:0] diff;
  logic [WIDE_W-1:0] q;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WIDE_W-1:0] ram_wdata;

  // ---------------------------------------------------------------- datapath helpers
  always_comb begin
    // no transfers are taken while in reset
    item_ready  = (state == ST_IDLE) && !rst;
    cfg_ready   = !rst;
    item_xfer   = item_valid && item_ready;
    result_xfer = result_valid && result_ready;
    r_cl        = clamp_radix(radix);
    x_ext       = WIDE_W'(index[USE_BITS-1:0]);
    // one-letter alphabet: word of index+1 zeros must fit
    x_too_big   = (x_ext >= WIDE_W'(MAX_LEN));
    prod        = (WIDE_W+RADIX_W)'(p) * (WIDE_W+RADIX_W)'(radix_used);
    // power needed for this letter is r^(m-1-pos)
    ridx        = m - LEN_W'(1) - pos;
    dig_next    = dig | (DIGIT_W'(ge) << bit_cnt);
    at_max      = (m == LEN_W'(MAX_LEN));
    is_last_pos = (pos == (m - LEN_W'(1)));
  end

  // power table: entry k holds r^k
  slwu_ram #(
    .WIDTH (WIDE_W),
    .DEPTH (MAX_LEN)
  ) u_pow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (q)
  );

  slwu_csub u_csub (
    .op   (op),
    .rem  (rem),
    .p    (p),
    .q    (q),
    .ge   (ge),
    .diff (diff)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_xfer) begin
          if (r_cl == RADIX_W'(1)) begin
            state_next = x_too_big ? ST_EMIT : ST_READ;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (!ge) begin
          state_next = ST_READ;
        end else if (at_max) begin
          state_next = ST_EMIT;
        end
      end
      ST_READ: begin
        state_next = unary ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (result_ready) begin
          state_next = last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = p;
    ram_re    = 1'b0;
    ram_raddr = ridx[ADDR_W-1:0];
    op.use_q  = 1'b0;
    op.shift  = bit_cnt;
    case (state)
      ST_IDLE: begin
        // r^0 goes in entry zero on every new item
        ram_we    = item_xfer;
        ram_wdata = WIDE_W'(1);
      end
      ST_SEARCH: begin
        ram_we    = ge && !at_max;
        ram_waddr = m[ADDR_W-1:0];
      end
      ST_READ: begin
        ram_re = !unary;
      end
      ST_DIV: begin
        op.use_q = 1'b1;
      end
      ST_EMIT: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      radix        <= RADIX_W'(2);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state_next == ST_EMIT);
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_radix;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_xfer) begin
          rem        <= x_ext;
          p          <= WIDE_W'(r_cl);
          m          <= LEN_W'(1);
          pos        <= '0;
          radix_used <= r_cl;
          unary      <= (r_cl == RADIX_W'(1));
          if (r_cl == RADIX_W'(1)) begin
            if (x_too_big) begin
              word_length <= '0;
              position    <= '0;
              digit       <= '0;
              last        <= 1'b1;
              too_long    <= 1'b1;
            end else begin
              m <= LEN_W'(x_ext) + LEN_W'(1);
            end
          end
        end
      end
      ST_SEARCH: begin
        if (ge) begin
          if (at_max) begin
            // word would exceed the maximum length
            word_length <= '0;
            position    <= '0;
            digit       <= '0;
            last        <= 1'b1;
            too_long    <= 1'b1;
          end else begin
            rem <= diff;
            m   <= m + LEN_W'(1);
            p   <= prod[WIDE_W-1:0];
          end
        end
      end
      ST_READ: begin
        bit_cnt <= '1;
        dig     <= '0;
        if (unary) begin
          word_length <= m;
          position    <= pos[POS_W-1:0];
          digit       <= '0;
          last        <= is_last_pos;
          too_long    <= 1'b0;
        end
      end
      ST_DIV: begin
        // restoring step: take q<<bit_cnt out of the remainder when it fits
        if (ge) begin
          rem <= diff;
        end
        dig     <= dig_next;
        bit_cnt <= bit_cnt - SHIFT_W'(1);
        if (bit_cnt == '0) begin
          word_length <= m;
          position    <= pos[POS_W-1:0];
          digit       <= dig_next;
          last        <= is_last_pos;
          too_long    <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (result_xfer && !last) begin
          pos <= pos + LEN_W'(1);
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  // ---------------------------------------------------------------- assertions
  `SLWU_ASSERT_IMP(a_valid_in_emit, clk, rst, result_valid, state == ST_EMIT)
  `SLWU_ASSERT_NXT(a_busy_after_item, clk, rst, item_xfer, state != ST_IDLE)
  `SLWU_ASSERT_IMP(a_too_long_shape, clk, rst, result_valid && too_long, last && (word_length == '0))
  `SLWU_ASSERT_IMP(a_pos_in_word, clk, rst, result_valid && !too_long, word_length > LEN_W'(position))
  `SLWU_ASSERT_IMP(a_search_bound, clk, rst, state == ST_SEARCH, m <= LEN_W'(MAX_LEN))

endmodule
